[hdl/fdc_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// fdc_pkg
// Types and constants for the single/double precision format converter.
// ============================================================================
package fdc_pkg;

    // Conversion direction carried in tuser
    typedef enum logic [0:0] {
        ACT_WIDEN  = 1'b0,
        ACT_NARROW = 1'b1
    } action_t;

    // Field widths of the two formats
    localparam int SGL_EXP_W  = 8;
    localparam int SGL_FRAC_W = 23;
    localparam int DBL_EXP_W  = 11;
    localparam int DBL_FRAC_W = 52;

    // Exponent codes and bias arithmetic
    localparam logic [SGL_EXP_W-1:0] SGL_EXP_MAX = 8'hff;
    localparam logic [DBL_EXP_W-1:0] DBL_EXP_MAX = 11'h7ff;
    localparam int SGL_BIAS  = 127;
    localparam int DBL_BIAS  = 1023;
    localparam logic [DBL_EXP_W-1:0] BIAS_DIFF = DBL_EXP_W'(DBL_BIAS - SGL_BIAS);
    // Lowest double exponent that overflows a single
    localparam logic [DBL_EXP_W-1:0] NARROW_OVF_EXP =
        DBL_EXP_W'(DBL_BIAS - SGL_BIAS + 255);

    // Fraction bits dropped when narrowing
    localparam int FRAC_SHIFT = DBL_FRAC_W - SGL_FRAC_W;

    // Stage 1: captured operand with classification
    typedef struct packed {
        action_t                 action;
        logic [63:0]             operand;
        logic [4:0]              lz;
        logic                    w_exp_zero;
        logic                    w_exp_max;
        logic                    w_man_zero;
        logic                    n_zero;
        logic                    n_special;
        logic                    n_over;
        logic                    n_under;
    } st1_t;

    // Stage 2: converted magnitude words
    typedef struct packed {
        action_t                 action;
        logic                    sign;
        logic [62:0]             w_word;
        logic [30:0]             n_word;
    } st2_t;

endpackage

[hdl/float_double_format_converter.sv]
`timescale 1ns / 1ps
// ============================================================================
// float_double_format_converter
// Pipelined IEEE 754 single <-> double conversion: widening with denormal
// normalisation, narrowing with half-up rounding, saturation and flush.
// ============================================================================
//
//  channel   | ports                         | contents
//  ----------+-------------------------------+------------------------------
//  input     | s_tvalid s_tready s_tdata/user| operand (64), action (tuser)
//  result    | m_tvalid m_tready m_tdata     | result (64)
//
//  One transfer per cycle sustained while m_tready is high; an input
//  transfer reaches m_tvalid through three registered stages (classify and
//  leading-zero count, shift/round, output register).
//  aresetn (synchronous, active low) empties all three stages.
//  A stage holds while the stage after it is full and stalled; bubbles
//  close up, so s_tready falls only when every stage is full and m_tready
//  is low.
//
module float_double_format_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] operand
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [63:0] result
);
    import fdc_pkg::*;

    logic        v1_reg, v2_reg, v3_reg;
    st1_t        s1_reg, s1_next;
    st2_t        s2_reg, s2_next;
    logic [63:0] res_reg, res_next;
    action_t     act3_reg;
    logic        rdy1, rdy2, rdy3;

    // Stage enables: a stage loads when empty or when its contents move on
    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    // ---------------- stage 1: classify ----------------
    logic [SGL_FRAC_W-1:0] in_man;
    logic [SGL_EXP_W-1:0]  in_sexp;
    logic [DBL_EXP_W-1:0]  in_dexp;
    logic [4:0]            lz_cnt;

    assign in_man  = s_tdata[SGL_FRAC_W-1:0];
    assign in_sexp = s_tdata[30:SGL_FRAC_W];
    assign in_dexp = s_tdata[62:DBL_FRAC_W];

    // Count leading zeros of the single fraction; highest set bit wins
    always_comb begin
        lz_cnt = 5'd0;
        for (int i = 0; i < SGL_FRAC_W; i++) begin
            if (in_man[i]) begin
                lz_cnt = 5'(SGL_FRAC_W - 1 - i);
            end
        end
    end

    always_comb begin
        s1_next.action     = action_t'(s_tuser);
        s1_next.operand    = s_tdata;
        s1_next.lz         = lz_cnt;
        s1_next.w_exp_zero = (in_sexp == '0);
        s1_next.w_exp_max  = (in_sexp == SGL_EXP_MAX);
        s1_next.w_man_zero = (in_man == '0);
        s1_next.n_zero     = (in_dexp == '0) && (s_tdata[DBL_FRAC_W-1:0] == '0);
        s1_next.n_special  = (in_dexp == DBL_EXP_MAX);
        s1_next.n_over     = (in_dexp >= NARROW_OVF_EXP);
        s1_next.n_under    = (in_dexp <= BIAS_DIFF);
    end

    // ---------------- stage 2: shift, rebias, round ----------------
    logic [SGL_FRAC_W-1:0] s2_man;
    logic [SGL_FRAC_W-1:0] s2_norm;
    logic [SGL_EXP_W-1:0]  s2_sexp;
    logic [DBL_EXP_W-1:0]  s2_dexp;
    logic [SGL_EXP_W-1:0]  s2_fe;
    logic [30:0]           s2_sum;

    assign s2_man  = s1_reg.operand[SGL_FRAC_W-1:0];
    assign s2_sexp = s1_reg.operand[30:SGL_FRAC_W];
    assign s2_dexp = s1_reg.operand[62:DBL_FRAC_W];
    // Bring the leading one to the top bit of the fraction field
    assign s2_norm = s2_man << s1_reg.lz;
    assign s2_fe   = SGL_EXP_W'(s2_dexp - BIAS_DIFF);
    // Round half-up; a carry out of the fraction lifts the exponent
    assign s2_sum  = {s2_fe, s1_reg.operand[DBL_FRAC_W-1:FRAC_SHIFT]}
                     + 31'(s1_reg.operand[FRAC_SHIFT-1]);

    always_comb begin
        s2_next.action = s1_reg.action;
        s2_next.sign   = (s1_reg.action == ACT_WIDEN) ? s1_reg.operand[31]
                                                      : s1_reg.operand[63];
        // Widening
        priority if (s1_reg.w_exp_zero && s1_reg.w_man_zero) begin
            s2_next.w_word = '0;
        end else if (s1_reg.w_exp_zero) begin
            // Denormal: exponent drops by one per shift past the first
            s2_next.w_word = {BIAS_DIFF - DBL_EXP_W'(s1_reg.lz),
                              s2_norm[SGL_FRAC_W-2:0], 1'b0,
                              {FRAC_SHIFT{1'b0}}};
        end else if (s1_reg.w_exp_max) begin
            s2_next.w_word = {DBL_EXP_MAX, s2_man, {FRAC_SHIFT{1'b0}}};
        end else begin
            s2_next.w_word = {DBL_EXP_W'(s2_sexp) + BIAS_DIFF, s2_man,
                              {FRAC_SHIFT{1'b0}}};
        end
        // Narrowing
        priority if (s1_reg.n_zero) begin
            s2_next.n_word = '0;
        end else if (s1_reg.n_special) begin
            s2_next.n_word = {SGL_EXP_MAX, s1_reg.operand[DBL_FRAC_W-1:FRAC_SHIFT]};
        end else if (s1_reg.n_over) begin
            s2_next.n_word = {SGL_EXP_MAX, {SGL_FRAC_W{1'b0}}};
        end else if (s1_reg.n_under) begin
            s2_next.n_word = '0;
        end else begin
            s2_next.n_word = s2_sum;
        end
    end

    // ---------------- stage 3: pack result ----------------
    always_comb begin
        unique case (s2_reg.action)
            ACT_WIDEN:  res_next = {s2_reg.sign, s2_reg.w_word};
            ACT_NARROW: res_next = {32'b0, s2_reg.sign, s2_reg.n_word};
            default:    res_next = '0;
        endcase
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // Payload: advance with each stage, hold while stalled
    always_ff @(posedge aclk) begin
        if (rdy1) s1_reg <= s1_next;
        if (rdy2) s2_reg <= s2_next;
        if (rdy3) begin
            res_reg  <= res_next;
            act3_reg <= s2_reg.action;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = res_reg;

    // ---------------- checks ----------------
    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && !m_tready))
        else $error("input stalled while pipeline had room");

    a_narrow_upper_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && act3_reg == ACT_NARROW) |-> (m_tdata[63:32] == 32'b0))
        else $error("narrowed result has upper bits set");

    a_full_refill: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && m_tvalid && m_tready) |=> m_tvalid)
        else $error("item in stage 2 lost on output transfer");

    a_stall_holds_stage2: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && v3_reg && !m_tready) |=> (v2_reg && $stable(s2_reg)))
        else $error("stage 2 changed while stalled");

endmodule
